[design/fbe_pkg.sv]
// ----------------------------------------------------------------------------
// fbe_pkg
// Shared constants, codes and types of the frame buffer blit engine.
// ----------------------------------------------------------------------------
`default_nettype none

package fbe_pkg;

	// Surface geometry; the store is addressed as {row, col}, so MAX_WIDTH
	// must stay a power of two.
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 64;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int ADDR_W     = COL_W + ROW_W;
	localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
	localparam int PIX_W      = 8;

	// Saturation limits in register widths
	localparam logic [8:0] SURF_W_MAX = 9'(MAX_WIDTH);
	localparam logic [6:0] SURF_H_MAX = 7'(MAX_HEIGHT);

	// Color key level and full-scale pixel value
	localparam logic [PIX_W-1:0] KEY_LEVEL = 8'd128;
	localparam logic [PIX_W-1:0] PIX_MAX   = 8'd255;

	// Register reset values
	localparam logic [8:0] RST_SURF_WIDTH  = 9'd160;
	localparam logic [6:0] RST_SURF_HEIGHT = 7'd43;
	localparam logic [8:0] RST_WIN_X       = 9'd0;
	localparam logic [6:0] RST_WIN_Y       = 7'd0;
	localparam logic [8:0] RST_WIN_WIDTH   = 9'd1;

	// Command codes
	typedef enum logic [2:0] {
		CMD_WRITE  = 3'd0,
		CMD_READ   = 3'd1,
		CMD_BLIT   = 3'd2,
		CMD_CROP   = 3'd3,
		CMD_INVERT = 3'd4,
		CMD_FILL   = 3'd5
	} cmd_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_SURF_WIDTH  = 3'd0,
		CFG_SURF_HEIGHT = 3'd1,
		CFG_WIN_X       = 3'd2,
		CFG_WIN_Y       = 3'd3,
		CFG_WIN_WIDTH   = 3'd4,
		CFG_OVERWRITE   = 3'd5
	} cfg_idx_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_SWEEP,
		ST_DRAIN
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;      // load the input transaction
		logic exec;        // execute the loaded transaction
		logic rd_cap;      // capture store read data as the result
		logic sweep_step;  // visit one surface pixel
		logic sweep_end;   // report the finished sweep
	} ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_read;     // loaded command reads the store
		logic is_sweep;    // loaded command walks a non-empty surface
		logic sweep_last;  // sweep counter sits on the last pixel
	} sts_t;

endpackage

`default_nettype wire

[design/fbe_ram.sv]
// ----------------------------------------------------------------------------
// fbe_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fbe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[design/fbe_ctrl.sv]
// ----------------------------------------------------------------------------
// fbe_ctrl
// Sequencer of the blit engine: accepts commands and steps the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module fbe_ctrl import fbe_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire sts_t sts,
	output logic      busy,
	output ctl_t      ctl
);

	state_t state_q, state_nx;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and commands
	always_comb begin
		state_nx = state_q;
		ctl      = '0;
		busy     = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctl.accept = 1'b1;
					state_nx   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ctl.exec = 1'b1;
				if (sts.is_sweep) begin
					state_nx = ST_SWEEP;
				end else if (sts.is_read) begin
					state_nx = ST_READ;
				end else begin
					// command ends in execute: take the next transaction at once
					busy = 1'b0;
					if (start) begin
						ctl.accept = 1'b1;
						state_nx   = ST_EXEC;
					end else begin
						state_nx = ST_IDLE;
					end
				end
			end
			ST_READ: begin
				ctl.rd_cap = 1'b1;
				busy       = 1'b0;
				if (start) begin
					ctl.accept = 1'b1;
					state_nx   = ST_EXEC;
				end else begin
					state_nx = ST_IDLE;
				end
			end
			ST_SWEEP: begin
				ctl.sweep_step = 1'b1;
				if (sts.sweep_last) begin
					state_nx = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				ctl.sweep_end = 1'b1;
				state_nx      = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[design/fbe_datapath.sv]
// ----------------------------------------------------------------------------
// fbe_datapath
// Registers, window and sweep counters, surface store and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module fbe_datapath import fbe_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire ctl_t         ctl,
	output sts_t              sts,
	input  wire logic [2:0]   cmd,
	input  wire logic [7:0]   pos_x,
	input  wire logic [5:0]   pos_y,
	input  wire logic [7:0]   value,
	input  wire logic         last,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_idx,
	input  wire logic [8:0]   cfg_data,
	output logic              done,
	output logic [7:0]        pixel,
	output logic              wrote,
	output logic              outside
);

	// Configuration registers
	logic [8:0] surf_width_q;
	logic [6:0] surf_height_q;
	logic [8:0] win_x_q;
	logic [6:0] win_y_q;
	logic [8:0] win_width_q;
	logic       overwrite_q;

	// Loaded transaction
	logic [2:0] cmd_q;
	logic [7:0] pos_x_q;
	logic [5:0] pos_y_q;
	logic [7:0] value_q;
	logic       last_q;

	// Window run position and sweep counters
	logic [7:0]       run_col_q;
	logic [7:0]       run_row_q;
	logic [COL_W-1:0] sw_col_q;
	logic [ROW_W-1:0] sw_row_q;

	// Invert write-back stage
	logic              valid_s1;
	logic [ADDR_W-1:0] addr_s1;

	logic rd_inside_q;

	// Derived sizes and positions
	logic [8:0]        sw;
	logic [6:0]        sh;
	logic [8:0]        ew;
	logic              nonempty;
	logic [10:0]       x_w;
	logic [9:0]        y_w;
	logic              in_w;
	logic              in_p;
	logic [ADDR_W-1:0] win_addr;
	logic [ADDR_W-1:0] pos_addr;
	logic [ADDR_W-1:0] exec_addr;
	logic [ADDR_W-1:0] sweep_addr;
	logic              exec_wr;
	logic              exec_out;
	logic              run_adv;
	logic              is_fill;
	logic [8:0]        col_inc;
	logic [8:0]        sw_col_inc;
	logic              res_fire;

	// Store ports
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [PIX_W-1:0]  ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [PIX_W-1:0]  ram_rdata;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			surf_width_q  <= RST_SURF_WIDTH;
			surf_height_q <= RST_SURF_HEIGHT;
			win_x_q       <= RST_WIN_X;
			win_y_q       <= RST_WIN_Y;
			win_width_q   <= RST_WIN_WIDTH;
			overwrite_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_SURF_WIDTH:  surf_width_q  <= cfg_data;
				CFG_SURF_HEIGHT: surf_height_q <= cfg_data[6:0];
				CFG_WIN_X:       win_x_q       <= cfg_data;
				CFG_WIN_Y:       win_y_q       <= cfg_data[6:0];
				CFG_WIN_WIDTH:   win_width_q   <= cfg_data;
				CFG_OVERWRITE:   overwrite_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Load the accepted transaction
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q   <= cmd;
			pos_x_q <= pos_x;
			pos_y_q <= pos_y;
			value_q <= value;
			last_q  <= last;
		end
	end

	// Saturate sizes
	always_comb begin
		sw = (surf_width_q > SURF_W_MAX) ? SURF_W_MAX : surf_width_q;
		sh = (surf_height_q > SURF_H_MAX) ? SURF_H_MAX : surf_height_q;
		if (win_width_q == 9'd0) begin
			ew = 9'd1;
		end else begin
			ew = (win_width_q > SURF_W_MAX) ? SURF_W_MAX : win_width_q;
		end
		nonempty = (sw != 9'd0) && (sh != 7'd0);
	end

	// Window and single-pixel position tests
	always_comb begin
		x_w      = {{2{win_x_q[8]}}, win_x_q} + {3'b000, run_col_q};
		y_w      = {{3{win_y_q[6]}}, win_y_q} + {2'b00, run_row_q};
		in_w     = !x_w[10] && (x_w[9:0] < {1'b0, sw})
		         && !y_w[9] && (y_w[8:0] < {2'b00, sh});
		in_p     = ({1'b0, pos_x_q} < sw) && ({1'b0, pos_y_q} < sh);
		win_addr = {y_w[ROW_W-1:0], x_w[COL_W-1:0]};
		pos_addr = {pos_y_q[ROW_W-1:0], pos_x_q[COL_W-1:0]};
		sweep_addr = {sw_row_q, sw_col_q};
		is_fill  = (cmd_q == CMD_FILL);
	end

	// Decode the loaded command
	always_comb begin
		exec_wr   = 1'b0;
		exec_out  = 1'b0;
		run_adv   = 1'b0;
		exec_addr = pos_addr;
		sts.is_read  = 1'b0;
		sts.is_sweep = 1'b0;
		unique case (cmd_q)
			CMD_WRITE: begin
				exec_wr  = in_p;
				exec_out = !in_p;
			end
			CMD_READ: begin
				sts.is_read = 1'b1;
			end
			CMD_BLIT: begin
				exec_addr = win_addr;
				exec_wr   = in_w && (overwrite_q || (value_q > KEY_LEVEL));
				exec_out  = !in_w;
				run_adv   = 1'b1;
			end
			CMD_CROP: begin
				exec_addr   = win_addr;
				sts.is_read = 1'b1;
				run_adv     = 1'b1;
			end
			CMD_INVERT, CMD_FILL: begin
				sts.is_sweep = nonempty;
			end
			default: ;
		endcase
		sts.sweep_last = ({1'b0, sw_col_q} == sw - 9'd1) && ({1'b0, sw_row_q} == sh - 7'd1);
	end

	// Advance the window run position
	assign col_inc = {1'b0, run_col_q} + 9'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_col_q <= '0;
			run_row_q <= '0;
		end else if (ctl.exec && run_adv) begin
			if (last_q) begin
				run_col_q <= '0;
				run_row_q <= '0;
			end else if (col_inc >= ew) begin
				run_col_q <= '0;
				run_row_q <= run_row_q + 8'd1;
			end else begin
				run_col_q <= col_inc[7:0];
			end
		end
	end

	// Step the sweep counters row-major over the surface
	assign sw_col_inc = {1'b0, sw_col_q} + 9'd1;

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			sw_col_q <= '0;
			sw_row_q <= '0;
		end else if (ctl.sweep_step) begin
			if (sw_col_inc == sw) begin
				sw_col_q <= '0;
				sw_row_q <= sw_row_q + ROW_W'(1);
			end else begin
				sw_col_q <= sw_col_inc[COL_W-1:0];
			end
		end
	end

	// Hold the write-back stage in the cycle after the sweep read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctl.sweep_step;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= sweep_addr;
	end

	// Store port selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = exec_addr;
		ram_wdata = value_q;
		if (valid_s1) begin
			ram_we    = 1'b1;
			ram_waddr = addr_s1;
			ram_wdata = is_fill ? value_q : PIX_MAX - ram_rdata;
		end else if (ctl.exec && exec_wr) begin
			ram_we = 1'b1;
		end
		ram_raddr = ctl.sweep_step ? sweep_addr : exec_addr;
	end

	fbe_ram #(
		.WIDTH(PIX_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Remember whether a pending read addressed the surface
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			rd_inside_q <= (cmd_q == CMD_READ) ? in_p : in_w;
		end
	end

	// Result registers
	assign res_fire = (ctl.exec && !sts.is_read && !sts.is_sweep) || ctl.rd_cap
	                  || ctl.sweep_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= res_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_cap) begin
			pixel   <= rd_inside_q ? ram_rdata : '0;
			wrote   <= 1'b0;
			outside <= !rd_inside_q;
		end else if (ctl.sweep_end) begin
			pixel   <= '0;
			wrote   <= 1'b1;
			outside <= 1'b0;
		end else if (ctl.exec) begin
			pixel   <= '0;
			wrote   <= exec_wr;
			outside <= exec_out;
		end
	end

endmodule

`default_nettype wire

[design/framebuffer_blit_engine_top.sv]
// ----------------------------------------------------------------------------
// framebuffer_blit_engine_top
// Byte-per-pixel surface with pixel access, clipped color-keyed blit,
// crop read-out, invert and fill.
//
//   Channel   Handshake             Payload
//   command   start / busy          cmd, pos_x, pos_y, value, last
//   result    done (one cycle)      pixel, wrote, outside
//   config    cfg_we                cfg_idx, cfg_data
//
// Write and blit finish in the execute state: a new command is accepted every cycle.
// Read and crop pass through execute and read, as the store's read port is registered.
// Invert and fill pass through execute, sweep and drain (execute alone on an empty
// surface): the sweep visits one store entry a cycle through the single write port.
// The result strobe follows the execute cycle (write, blit, spare codes, empty sweep), the
// read cycle (read, crop) or the drain cycle (invert, fill). Reset clears
// control state and loads the register defaults; store contents are undefined
// until written or filled, so there is no clearing pass. The receiver cannot
// stall; busy alone holds off start.
// ----------------------------------------------------------------------------
`default_nettype none

module framebuffer_blit_engine_top import fbe_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [2:0] cmd,
	input  wire logic [7:0] pos_x,
	input  wire logic [5:0] pos_y,
	input  wire logic [7:0] value,
	input  wire logic       last,
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_idx,
	input  wire logic [8:0] cfg_data,
	output logic            done,
	output logic [7:0]      pixel,
	output logic            wrote,
	output logic            outside
);

	ctl_t ctl;
	sts_t sts;

	fbe_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.busy  (busy),
		.ctl   (ctl)
	);

	fbe_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.sts     (sts),
		.cmd     (cmd),
		.pos_x   (pos_x),
		.pos_y   (pos_y),
		.value   (value),
		.last    (last),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.done    (done),
		.pixel   (pixel),
		.wrote   (wrote),
		.outside (outside)
	);

	// An accepted transaction executes in the next cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ctl.exec)
		else $error("accepted transaction did not execute");

	// A sweep never overlaps a new transaction
	a_sweep_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.sweep_step |-> busy)
		else $error("transaction accepted during sweep");

	// Read data is captured only right after a read was issued
	a_rd_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd_cap |-> ($past(ctl.exec) && $past(sts.is_read)))
		else $error("read capture without issued read");

	// Every result strobe traces back to one completing step
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(ctl.exec) || $past(ctl.rd_cap) || $past(ctl.sweep_end)))
		else $error("result strobe without completed command");

endmodule

`default_nettype wire

[tb/framebuffer_blit_engine_top_test.sv]
// ----------------------------------------------------------------------------
// framebuffer_blit_engine_top_test
// Self-checking bench for the frame buffer blit engine. A table of directed
// commands opens the run; random phases with fresh register settings follow.
// Every accepted transaction is run through an in-bench copy of the surface
// and window walker, and each result strobe is compared with the oldest
// pending expectation.
// ----------------------------------------------------------------------------
`default_nettype none

module framebuffer_blit_engine_top_test import fbe_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// Spare command codes, no effect on the block
	localparam logic [2:0] CMD_SPARE6 = 3'd6;
	localparam logic [2:0] CMD_SPARE7 = 3'd7;

	localparam int RANDOM_ITEMS = 1650;
	localparam int PLAN_LEN     = 37;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] pos_x;
		logic [5:0] pos_y;
		logic [7:0] value;
		logic       last;
	} command_t;

	typedef struct packed {
		logic [7:0] pixel;
		logic       wrote;
		logic       outside;
	} result_t;

	typedef struct packed {
		logic       is_cfg;
		cfg_idx_t   idx;
		logic [8:0] data;
		command_t   op;
		logic       typed;
		result_t    res;
	} plan_row_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [2:0] cmd;
	logic [7:0] pos_x;
	logic [5:0] pos_y;
	logic [7:0] value;
	logic       last;
	logic       cfg_we;
	logic [2:0] cfg_idx;
	logic [8:0] cfg_data;
	logic       done;
	logic [7:0] pixel;
	logic       wrote;
	logic       outside;

	// Bench copy of the surface, the window walker and the registers
	logic [7:0]        surface_copy [DEPTH];
	int                run_col;
	logic [7:0]        run_row;
	logic [8:0]        surf_w_q;
	logic [6:0]        surf_h_q;
	logic signed [8:0] win_x_q;
	logic signed [6:0] win_y_q;
	logic [8:0]        win_w_q;
	logic              overwrite_q;

	result_t awaited_results [$];
	int      mismatches;
	int      random_items;

	framebuffer_blit_engine_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.value    (value),
		.last     (last),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.done     (done),
		.pixel    (pixel),
		.wrote    (wrote),
		.outside  (outside)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Effective geometry after saturation
	function automatic int surf_cols();
		return (surf_w_q > MAX_WIDTH) ? MAX_WIDTH : int'(surf_w_q);
	endfunction

	function automatic int surf_rows();
		return (surf_h_q > MAX_HEIGHT) ? MAX_HEIGHT : int'(surf_h_q);
	endfunction

	function automatic int win_cols();
		if (win_w_q == 0)
			return 1;
		return (win_w_q > MAX_WIDTH) ? MAX_WIDTH : int'(win_w_q);
	endfunction

	// Execute one command on the bench surface and return its result
	function automatic result_t execute_command(command_t c);
		result_t     r;
		int          cols;
		int          rows;
		int          px;
		int          py;
		int          row;
		int          col;
		int unsigned addr;
		r = '0;
		cols = surf_cols();
		rows = surf_rows();
		case (c.cmd)
			CMD_WRITE, CMD_READ: begin
				if (int'(c.pos_x) < cols && int'(c.pos_y) < rows) begin
					addr = int'(c.pos_y) * MAX_WIDTH + int'(c.pos_x);
					if (c.cmd == CMD_WRITE) begin
						surface_copy[addr] = c.value;
						r.wrote = 1'b1;
					end else begin
						r.pixel = surface_copy[addr];
					end
				end else begin
					r.outside = 1'b1;
				end
			end
			CMD_BLIT, CMD_CROP: begin
				px = int'(win_x_q) + run_col;
				py = int'(win_y_q) + int'(run_row);
				if (px >= 0 && py >= 0 && px < cols && py < rows) begin
					addr = py * MAX_WIDTH + px;
					if (c.cmd == CMD_BLIT) begin
						// color key: keep the surface unless overwrite is set or the value is above the key level
						if (overwrite_q || c.value > KEY_LEVEL) begin
							surface_copy[addr] = c.value;
							r.wrote = 1'b1;
						end
					end else begin
						r.pixel = surface_copy[addr];
					end
				end else begin
					r.outside = 1'b1;
				end
				// advance the window position, back to its origin on last
				if (c.last) begin
					run_col = 0;
					run_row = '0;
				end else begin
					run_col++;
					if (run_col >= win_cols()) begin
						run_col = 0;
						run_row++;
					end
				end
			end
			CMD_INVERT, CMD_FILL: begin
				for (row = 0; row < rows; row++)
					for (col = 0; col < cols; col++) begin
						addr = row * MAX_WIDTH + col;
						if (c.cmd == CMD_INVERT)
							surface_copy[addr] = PIX_MAX - surface_copy[addr];
						else
							surface_copy[addr] = c.value;
					end
				r.wrote = (cols != 0 && rows != 0);
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Drive one command and hold it until the block takes the transaction
	task automatic issue(command_t c, logic typed, result_t given);
		result_t predicted;
		@(negedge clk);
		start = 1'b1;
		cmd   = c.cmd;
		pos_x = c.pos_x;
		pos_y = c.pos_y;
		value = c.value;
		last  = c.last;
		do
			@(posedge clk);
		while (busy);
		predicted = execute_command(c);
		if (typed)
			predicted = given;
		awaited_results = {awaited_results, predicted};
	endtask

	// Drop start and wait until every pending result has come back
	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		do
			@(posedge clk);
		while (awaited_results.size() != 0 || busy);
	endtask

	task automatic set_reg(cfg_idx_t idx, logic [8:0] data);
		@(negedge clk);
		cfg_we   = 1'b1;
		cfg_idx  = idx;
		cfg_data = data;
		@(posedge clk);
		case (idx)
			CFG_SURF_WIDTH:  surf_w_q = data;
			CFG_SURF_HEIGHT: surf_h_q = data[6:0];
			CFG_WIN_X:       win_x_q = data;
			CFG_WIN_Y:       win_y_q = data[6:0];
			CFG_WIN_WIDTH:   win_w_q = data;
			CFG_OVERWRITE:   overwrite_q = data[0];
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Send one transaction, sometimes with a random idle gap ahead of it
	task automatic push_command(command_t c, logic gaps);
		int idle;
		if (gaps && ($urandom % 10) < 3) begin
			idle = (($urandom % 8) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
			@(negedge clk);
			start = 1'b0;
			repeat (idle) @(posedge clk);
		end
		issue(c, 1'b0, '0);
	endtask

	// Pick a fresh setting for every register, extremes included
	task automatic configure_random();
		int         sx;
		int         sy;
		logic [8:0] wdat;
		logic [6:0] hdat;
		logic [8:0] wwid;
		case ($urandom % 10)
			0, 1, 2, 3, 4, 5: wdat = 9'($urandom_range(1, 24));
			6: begin
				case ($urandom % 4)
					0: wdat = 9'd0;
					1: wdat = 9'd1;
					2: wdat = 9'd256;
					default: wdat = 9'd511;
				endcase
			end
			7: wdat = 9'($urandom_range(100, 256));
			default: wdat = 9'($urandom_range(0, 511));
		endcase
		case ($urandom % 10)
			0, 1, 2, 3, 4, 5: hdat = 7'($urandom_range(1, 12));
			6: begin
				case ($urandom % 4)
					0: hdat = 7'd0;
					1: hdat = 7'd1;
					2: hdat = 7'd64;
					default: hdat = 7'd127;
				endcase
			end
			default: hdat = 7'($urandom_range(0, 127));
		endcase
		set_reg(CFG_SURF_WIDTH, wdat);
		set_reg(CFG_SURF_HEIGHT, {2'b00, hdat});

		// keep most windows near the surface so the runs hit it
		case ($urandom % 8)
			0: sx = ($urandom % 2) ? -256 : 255;
			1: sx = int'($urandom_range(0, 511)) - 256;
			default: begin
				sx = int'($urandom_range(0, surf_cols() + 8)) - 8;
				if (sx > 255)
					sx = 255;
			end
		endcase
		case ($urandom % 8)
			0: sy = ($urandom % 2) ? -64 : 63;
			1: sy = int'($urandom_range(0, 127)) - 64;
			default: begin
				sy = int'($urandom_range(0, surf_rows() + 4)) - 4;
				if (sy > 63)
					sy = 63;
			end
		endcase
		set_reg(CFG_WIN_X, 9'(sx));
		set_reg(CFG_WIN_Y, {2'b00, 7'(sy)});

		case ($urandom % 10)
			0, 1, 2, 3, 4, 5: wwid = 9'($urandom_range(1, 8));
			6: begin
				case ($urandom % 4)
					0: wwid = 9'd0;
					1: wwid = 9'd1;
					2: wwid = 9'd256;
					default: wwid = 9'd511;
				endcase
			end
			7: wwid = 9'($urandom_range(9, 40));
			default: wwid = 9'($urandom_range(0, 511));
		endcase
		set_reg(CFG_WIN_WIDTH, wwid);
		set_reg(CFG_OVERWRITE, 9'($urandom % 2));
	endtask

	// One phase of random traffic: mostly whole blit and crop runs
	task automatic run_phase();
		int       budget;
		int       n;
		int       kind;
		int       len;
		int       i;
		logic     gaps;
		logic     close;
		logic     swept;
		logic     big;
		command_t c;
		budget = $urandom_range(20, 60);
		gaps   = ($urandom % 4) != 0;
		swept  = 1'b0;
		big    = surf_cols() * surf_rows() > 1024;
		n      = 0;
		while (n < budget) begin
			kind = $urandom % 100;
			if (kind < 65) begin
				c.cmd = (kind < 40) ? CMD_BLIT : CMD_CROP;
				if (win_cols() <= 16)
					len = win_cols() * $urandom_range(1, 3);
				else
					len = $urandom_range(1, 48);
				close = ($urandom % 10) != 0;
				for (i = 0; i < len; i++) begin
					c.pos_x = 8'($urandom);
					c.pos_y = 6'($urandom);
					// lean on values around the color key
					if (($urandom % 4) == 0) begin
						case ($urandom % 5)
							0: c.value = 8'd0;
							1: c.value = 8'd127;
							2: c.value = KEY_LEVEL;
							3: c.value = 8'd129;
							default: c.value = PIX_MAX;
						endcase
					end else begin
						c.value = 8'($urandom);
					end
					c.last = close && (i == len - 1);
					push_command(c, gaps);
				end
				n += len;
			end else if (kind < 95) begin
				c.cmd = (kind < 80) ? CMD_WRITE : CMD_READ;
				if (($urandom % 4) != 0 && surf_cols() > 0 && surf_rows() > 0) begin
					c.pos_x = 8'($urandom_range(0, surf_cols() - 1));
					c.pos_y = 6'($urandom_range(0, surf_rows() - 1));
				end else begin
					c.pos_x = 8'($urandom);
					c.pos_y = 6'($urandom);
				end
				c.value = 8'($urandom);
				c.last  = 1'($urandom);
				push_command(c, gaps);
				n++;
			end else if (kind < 97 && (!big || (!swept && ($urandom % 3) == 0))) begin
				// whole-surface sweeps are slow: at most one big one per phase
				c.cmd   = ($urandom % 2) ? CMD_INVERT : CMD_FILL;
				c.pos_x = 8'($urandom);
				c.pos_y = 6'($urandom);
				c.value = 8'($urandom);
				c.last  = 1'($urandom);
				swept   = 1'b1;
				push_command(c, gaps);
				n++;
			end else begin
				c.cmd   = ($urandom % 2) ? CMD_SPARE6 : CMD_SPARE7;
				c.pos_x = 8'($urandom);
				c.pos_y = 6'($urandom);
				c.value = 8'($urandom);
				c.last  = 1'($urandom);
				push_command(c, gaps);
				n++;
			end
		end
		random_items += n;
	endtask

	// Directed table: register writes and commands, results typed in where obvious
	plan_row_t plan [PLAN_LEN] = '{
		// full surface, then fill it so every entry is defined
		'{1'b1, CFG_SURF_WIDTH,  9'd256, '0, 1'b0, '0},
		'{1'b1, CFG_SURF_HEIGHT, 9'd64,  '0, 1'b0, '0},
		'{1'b0, CFG_SURF_WIDTH, 9'd0, '{CMD_FILL, 8'd0, 6'd0, 8'h5A, 1'b0}, 1'b1, '{8'd0, 1'b1, 1'b0}},
		'{1'b0, CFG_SURF_WIDTH, 9'd0, '{CMD_WRITE, 8'd255, 6'd63, 8'hFF, 1'b0}, 1'b1,
			'{8'd0, 1'b1, 1'b0}},
		'{1'b0, CFG_SURF_WIDTH, 9'd0, '{CMD_READ, 8'd255, 6'd63, 8'h00, 1'b0}, 1'b1,
			'{8'hFF, 1'b0, 1'b0}},
		'{1'b0, CFG_SURF_WIDTH, 9'd0, '{CMD_WRITE, 8'd0, 6'd0, 8'h00, 1'b1}, 1'b1,
			'{8'd0, 1'b1, 1'b0}},
		'{1'b0, CFG_SURF_WIDTH, 9'd0, '{CMD_READ, 8'd0, 6'd0, 8'hFF, 1'b0}, 1'b1,
			'{8'h00, 1'b0, 1'b0}},
		'{1'b0, CFG_SURF_WIDTH, 9'd0, '{CMD_READ, 8'd128, 6'd32, 8'h00, 1'b0}, 1'b1,
			'{8'h5A, 1'b0, 1'b0}},
		// reset-size surface: single accesses just past the edges, a spare code and an invert
		'{1'b1, CFG_SURF_WIDTH,  9'd160, '0, 1'b0, '0},
		'{1'b1, CFG_SURF_HEIGHT, 9'd43,  '0, 1'b0, '0},
		'{1'b0, CFG_SURF_WIDTH, 9'd0, '{CMD_WRITE, 8'd160, 6'd0, 8'h11, 1'b0}, 1'b1,
			'{8'd0, 1'b0, 1'b1}},
		'{1'b0, CFG_SURF_WIDTH, 9'd0, '{CMD_READ, 8'd0, 6'd43, 8'h00, 1'b0}, 1'b1,
			'{8'd0, 1'b0, 1'b1}},
		'{1'b0, CFG_SURF_WIDTH, 9'd0, '{CMD_SPARE6, 8'hFF, 6'h3F, 8'hFF, 1'b1}, 1'b1, '0},
		'{1'b0, CFG_SURF_WIDTH, 9'd0, '{CMD_INVERT, 8'd0, 6'd0, 8'd0, 1'b0}, 1'b1,
			'{8'd0, 1'b1, 1'b0}},
		// two-wide window hanging off the top left corner
		'{1'b1, CFG_WIN_X,     9'h1FF, '0, 1'b0, '0},
		'{1'b1, CFG_WIN_Y,     9'h07F, '0, 1'b0, '0},
		'{1'b1, CFG_WIN_WIDTH, 9'd2,   '0, 1'b0, '0},
		'{1'b1, CFG_OVERWRITE, 9'd0,   '0, 1'b0, '0},
		'{1'b0, CFG_SURF_WIDTH, 9'd0, '{CMD_BLIT, 8'd0, 6'd0, 8'hFF, 1'b0}, 1'b0, '0},
		'{1'b0, CFG_SURF_WIDTH, 9'd0, '{CMD_BLIT, 8'd0, 6'd0, 8'hFF, 1'b0}, 1'b0, '0},
		'{1'b0, CFG_SURF_WIDTH, 9'd0, '{CMD_BLIT, 8'd0, 6'd0, 8'h00, 1'b0}, 1'b0, '0},
		'{1'b0, CFG_SURF_WIDTH, 9'd0, '{CMD_BLIT, 8'd0, 6'd0, 8'h80, 1'b0}, 1'b0, '0},
		'{1'b0, CFG_SURF_WIDTH, 9'd0, '{CMD_BLIT, 8'd0, 6'd0, 8'h00, 1'b0}, 1'b0, '0},
		'{1'b0, CFG_SURF_WIDTH, 9'd0, '{CMD_BLIT, 8'd0, 6'd0, 8'hC8, 1'b1}, 1'b0, '0},
		'{1'b0, CFG_SURF_WIDTH, 9'd0, '{CMD_CROP, 8'd0, 6'd0, 8'd0, 1'b0}, 1'b0, '0},
		'{1'b0, CFG_SURF_WIDTH, 9'd0, '{CMD_CROP, 8'd0, 6'd0, 8'd0, 1'b0}, 1'b0, '0},
		'{1'b0, CFG_SURF_WIDTH, 9'd0, '{CMD_CROP, 8'd0, 6'd0, 8'd0, 1'b0}, 1'b0, '0},
		'{1'b0, CFG_SURF_WIDTH, 9'd0, '{CMD_CROP, 8'd0, 6'd0, 8'd0, 1'b0}, 1'b0, '0},
		'{1'b0, CFG_SURF_WIDTH, 9'd0, '{CMD_CROP, 8'd0, 6'd0, 8'd0, 1'b0}, 1'b0, '0},
		'{1'b0, CFG_SURF_WIDTH, 9'd0, '{CMD_CROP, 8'd0, 6'd0, 8'd0, 1'b1}, 1'b0, '0},
		'{1'b1, CFG_OVERWRITE, 9'd1, '0, 1'b0, '0},
		// empty surface, then oversized registers that saturate
		'{1'b1, CFG_SURF_WIDTH, 9'd0, '0, 1'b0, '0},
		'{1'b0, CFG_SURF_WIDTH, 9'd0, '{CMD_INVERT, 8'd0, 6'd0, 8'd0, 1'b0}, 1'b1, '0},
		'{1'b0, CFG_SURF_WIDTH, 9'd0, '{CMD_READ, 8'd0, 6'd0, 8'd0, 1'b0}, 1'b1,
			'{8'd0, 1'b0, 1'b1}},
		'{1'b1, CFG_SURF_WIDTH,  9'd511, '0, 1'b0, '0},
		'{1'b1, CFG_SURF_HEIGHT, 9'd127, '0, 1'b0, '0},
		'{1'b0, CFG_SURF_WIDTH, 9'd0, '{CMD_READ, 8'd255, 6'd63, 8'd0, 1'b0}, 1'b0, '0}
	};

	// Compare each result strobe with the oldest pending expectation
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				if (mismatches < 10)
					$display("result pixel %02h wrote %0d outside %0d with no transaction pending",
						pixel, wrote, outside);
				mismatches++;
			end else begin
				want = awaited_results.pop_front();
				if (pixel !== want.pixel || wrote !== want.wrote || outside !== want.outside) begin
					if (mismatches < 10)
						$display("mismatch: pixel %02h/%02h wrote %0d/%0d outside %0d/%0d (exp/act)",
							want.pixel, pixel, want.wrote, wrote, want.outside, outside);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int i;
		arst_n      = 1'b0;
		start       = 1'b0;
		cmd         = CMD_WRITE;
		pos_x       = '0;
		pos_y       = '0;
		value       = '0;
		last        = 1'b0;
		cfg_we      = 1'b0;
		cfg_idx     = CFG_SURF_WIDTH;
		cfg_data    = '0;
		mismatches  = 0;
		random_items = 0;
		run_col     = 0;
		run_row     = '0;
		surf_w_q    = RST_SURF_WIDTH;
		surf_h_q    = RST_SURF_HEIGHT;
		win_x_q     = RST_WIN_X;
		win_y_q     = RST_WIN_Y;
		win_w_q     = RST_WIN_WIDTH;
		overwrite_q = 1'b0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// walk the directed table
		for (i = 0; i < PLAN_LEN; i++) begin
			if (plan[i].is_cfg) begin
				settle();
				set_reg(plan[i].idx, plan[i].data);
			end else begin
				issue(plan[i].op, plan[i].typed, plan[i].res);
			end
		end

		// random phases, each under a fresh register setting
		while (random_items < RANDOM_ITEMS) begin
			settle();
			configure_random();
			run_phase();
		end

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && awaited_results.size() == 0)
			$display("framebuffer_blit_engine_top test passed");
		else
			$display("framebuffer_blit_engine_top test failed");
		$finish;
	end

	// Hard stop for a hung run
	initial begin
		#400_000_000;
		$display("framebuffer_blit_engine_top test failed");
		$finish;
	end

endmodule

`default_nettype wire
